FILE: rtl/core/flag_escape_deframer_crc16_macros.svh
// ---------------------------------------------------------------------------
// flag_escape_deframer_crc16 assertion macros
// Shared property forms for the deframer checks.
// ---------------------------------------------------------------------------
`ifndef FLAG_ESCAPE_DEFRAMER_CRC16_MACROS_SVH
`define FLAG_ESCAPE_DEFRAMER_CRC16_MACROS_SVH

// same-cycle implication
`define FEDC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FEDC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/fedc_pkg.sv
// ---------------------------------------------------------------------------
// fedc_pkg
// Types, byte codes and CRC step shared by the deframer modules.
// ---------------------------------------------------------------------------
package fedc_pkg;

	localparam logic [7:0] FLAG_BYTE    = 8'h7E;
	localparam logic [7:0] ESC_BYTE     = 8'h7D;
	localparam logic [7:0] ESC_FOR_ESC  = 8'h5D;
	localparam logic [7:0] ESC_FOR_FLAG = 8'h5E;
	localparam logic [15:0] CRC_POLY    = 16'h1021;
	localparam logic [7:0] CFG_RESET    = 8'd15;

	localparam logic RES_DATA    = 1'b0;
	localparam logic RES_SUMMARY = 1'b1;

	localparam logic REG_MIN_LENGTH = 1'b0;
	localparam logic REG_CRC_SPAN   = 1'b1;

	typedef enum logic [1:0] {
		CMD_OPEN,
		CMD_DATA,
		CMD_CLOSE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
	} cmd_t;

	typedef struct packed {
		logic [7:0] min_length;
		logic [7:0] crc_span;
	} cfg_t;

	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

FILE: rtl/core/flag_escape_deframer_crc16.sv
// An accepted word is stored in the middle queue, then its result in the result queue; the result ports show its head.
// Throughput: one word per cycle while neither queue is full; the front classifier and back CRC unit each handle one.
// A stall on the result side fills the result and middle queues before full rises.
// Reset (arst_n low): hunting for a flag, counts and CRC cleared, both registers 15.
// ---------------------------------------------------------------------------
// flag_escape_deframer_crc16
// Flag-delimited byte-stuffing deframer with CRC-16 and frame statistics.
// ---------------------------------------------------------------------------
`include "flag_escape_deframer_crc16_macros.svh"

module flag_escape_deframer_crc16 import fedc_pkg::*; #(
	parameter int MAX_FRAME = 256,
	parameter int MID_DEPTH = 4,
	parameter int OUT_DEPTH = 4,
	localparam int LEN_W    = $clog2(MAX_FRAME + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [7:0]       in_byte,
	output logic             full,
	output logic             empty,
	input  logic             pop,
	output logic             result_kind,
	output logic [7:0]       data_byte,
	output logic [LEN_W-1:0] frame_length,
	output logic [15:0]      frame_crc,
	output logic             length_ok,
	output logic [31:0]      frames_seen,
	output logic [31:0]      frames_good,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int CMD_W = $bits(cmd_t);
	localparam int RES_W = 1 + 8 + LEN_W + 16 + 1 + 32 + 32;

	cfg_t             cfg_q;
	logic             cmd_push;
	cmd_t             cmd_in;
	logic             mid_full;
	logic             mid_empty;
	logic [CMD_W-1:0] mid_head;
	logic             cmd_pop;
	logic             res_push;
	logic [RES_W-1:0] res;
	logic             out_full;
	logic [RES_W-1:0] out_head;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_length <= CFG_RESET;
			cfg_q.crc_span   <= CFG_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_MIN_LENGTH: cfg_q.min_length <= pwdata[7:0];
				REG_CRC_SPAN:   cfg_q.crc_span   <= pwdata[7:0];
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MIN_LENGTH: prdata = {24'h0, cfg_q.min_length};
			REG_CRC_SPAN:   prdata = {24'h0, cfg_q.crc_span};
			default:        prdata = 32'h0;
		endcase
	end

	assign full = mid_full;

	fedc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.in_byte  (in_byte),
		.stall    (mid_full),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	fedc_queue #(
		.WIDTH (CMD_W),
		.DEPTH (MID_DEPTH)
	) u_mid_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data (cmd_in),
		.pop       (cmd_pop),
		.head      (mid_head),
		.full      (mid_full),
		.empty     (mid_empty)
	);

	fedc_back #(
		.MAX_FRAME (MAX_FRAME),
		.LEN_W     (LEN_W),
		.RES_W     (RES_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (!mid_empty),
		.cmd       (cmd_t'(mid_head)),
		.res_ready (!out_full),
		.cmd_pop   (cmd_pop),
		.res_push  (res_push),
		.res       (res)
	);

	fedc_queue #(
		.WIDTH (RES_W),
		.DEPTH (OUT_DEPTH)
	) u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res),
		.pop       (pop),
		.head      (out_head),
		.full      (out_full),
		.empty     (empty)
	);

	assign {result_kind, data_byte, frame_length, frame_crc, length_ok,
		frames_seen, frames_good} = out_head;

	`FEDC_ASSERT_NOW(a_no_push_into_full_mid, cmd_push, !mid_full, "word pushed into full middle queue")
	`FEDC_ASSERT_NEXT(a_mid_holds_pushed_word, cmd_push, !mid_empty, "pushed word lost from middle queue")
	`FEDC_ASSERT_NOW(a_summary_has_both_flags, !empty && result_kind == RES_SUMMARY, frame_length >= LEN_W'(2) && frames_seen != 32'h0, "summary with impossible length or count")
	`FEDC_ASSERT_NOW(a_data_fields_clear, !empty && result_kind == RES_DATA, frame_crc == 16'h0 && frames_seen == 32'h0 && !length_ok, "data result carries summary fields")

endmodule

FILE: rtl/core/fedc_queue.sv
// ---------------------------------------------------------------------------
// fedc_queue
// Small first-in first-out word queue with registered storage.
// ---------------------------------------------------------------------------
module fedc_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] n;
		if (p == PTR_W'(DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + PTR_W'(1);
		end
		return n;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

FILE: rtl/core/fedc_front.sv
// ---------------------------------------------------------------------------
// fedc_front
// Hunts for the opening flag, undoes escapes and classifies each word.
// ---------------------------------------------------------------------------
module fedc_front import fedc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] in_byte,
	input  logic       stall,
	output logic       cmd_push,
	output cmd_t       cmd
);

	logic in_frame_q;
	logic esc_q;
	logic in_frame_d;
	logic esc_d;

	always_comb begin
		cmd_push   = 1'b0;
		cmd.kind   = CMD_DATA;
		cmd.data   = in_byte;
		in_frame_d = in_frame_q;
		esc_d      = esc_q;
		if (push && !stall) begin
			if (!in_frame_q) begin
				if (in_byte == FLAG_BYTE) begin
					cmd_push   = 1'b1;
					cmd.kind   = CMD_OPEN;
					in_frame_d = 1'b1;
					esc_d      = 1'b0;
				end
			end else if (in_byte == FLAG_BYTE) begin
				cmd_push   = 1'b1;
				cmd.kind   = CMD_CLOSE;
				in_frame_d = 1'b0;
				esc_d      = 1'b0;
			end else if (esc_q) begin
				esc_d = 1'b0;
				case (in_byte)
					ESC_FOR_ESC: begin
						cmd_push = 1'b1;
						cmd.data = ESC_BYTE;
					end
					ESC_FOR_FLAG: begin
						cmd_push = 1'b1;
						cmd.data = FLAG_BYTE;
					end
					ESC_BYTE: begin
						esc_d = 1'b1;
					end
					default: begin
						cmd_push = 1'b1;
					end
				endcase
			end else if (in_byte == ESC_BYTE) begin
				esc_d = 1'b1;
			end else begin
				cmd_push = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			esc_q      <= 1'b0;
		end else begin
			in_frame_q <= in_frame_d;
			esc_q      <= esc_d;
		end
	end

endmodule

FILE: rtl/core/fedc_back.sv
// ---------------------------------------------------------------------------
// fedc_back
// Counts and checksums stored words and builds data and summary results.
// ---------------------------------------------------------------------------
module fedc_back import fedc_pkg::*; #(
	parameter int MAX_FRAME = 256,
	parameter int LEN_W     = $clog2(MAX_FRAME + 1),
	parameter int RES_W     = 1 + 8 + LEN_W + 16 + 1 + 32 + 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             cmd_valid,
	input  cmd_t             cmd,
	input  logic             res_ready,
	output logic             cmd_pop,
	output logic             res_push,
	output logic [RES_W-1:0] res
);

	localparam int CMP_W = (LEN_W > 8) ? LEN_W : 8;

	logic [LEN_W-1:0] count_q;
	logic [15:0]      crc_q;
	logic [31:0]      seen_q;
	logic [31:0]      good_q;

	logic             go;
	logic             opening;
	logic             closing;
	logic [LEN_W-1:0] base_count;
	logic [15:0]      base_crc;
	logic [LEN_W-1:0] new_count;
	logic [15:0]      new_crc;
	logic             ok;
	logic [31:0]      seen_next;
	logic [31:0]      good_next;

	assign go       = cmd_valid && res_ready;
	assign cmd_pop  = go;
	assign res_push = go;
	assign opening  = (cmd.kind == CMD_OPEN);
	assign closing  = (cmd.kind == CMD_CLOSE);

	always_comb begin
		base_count = opening ? '0 : count_q;
		base_crc   = opening ? '0 : crc_q;
		new_count  = base_count;
		new_crc    = base_crc;
		if (base_count < LEN_W'(MAX_FRAME)) begin
			new_count = base_count + LEN_W'(1);
			if (CMP_W'(base_count) < CMP_W'(cfg.crc_span)) begin
				new_crc = crc_update(base_crc, cmd.data);
			end
		end
		ok        = (CMP_W'(new_count) >= CMP_W'(cfg.min_length));
		seen_next = seen_q + 32'd1;
		good_next = good_q + 32'(ok);
	end

	always_comb begin
		if (closing) begin
			res = {RES_SUMMARY, cmd.data, new_count, new_crc, ok, seen_next, good_next};
		end else begin
			res = {RES_DATA, cmd.data, {LEN_W{1'b0}}, 16'h0000, 1'b0, 32'h0, 32'h0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			crc_q   <= '0;
			seen_q  <= '0;
			good_q  <= '0;
		end else if (go) begin
			count_q <= new_count;
			crc_q   <= new_crc;
			if (closing) begin
				seen_q <= seen_next;
				good_q <= good_next;
			end
		end
	end

endmodule
